// File: rtl/mandelbrot_escape_count_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MANDELBROT_ESCAPE_COUNT_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_CORE_DEFINES_SVH
// Property that must hold whenever the antecedent holds, outside reset.
`define MEC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Same, consequent checked in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/mec_pkg.sv
//------------------------------------------------------------------------------
// mec_pkg
// Types and constants shared by the escape count core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package mec_pkg;
  localparam int unsigned CoordW = 12;
  localparam int unsigned BoundW = 31;
  localparam int unsigned GridW  = 13;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 5;

  localparam logic [AddrW-1:0] RegReMin  = 5'd0;
  localparam logic [AddrW-1:0] RegReMax  = 5'd4;
  localparam logic [AddrW-1:0] RegImMin  = 5'd8;
  localparam logic [AddrW-1:0] RegImMax  = 5'd12;
  localparam logic [AddrW-1:0] RegWidth  = 5'd16;
  localparam logic [AddrW-1:0] RegHeight = 5'd20;
  localparam logic [AddrW-1:0] RegLimit  = 5'd24;

  // Point handed from the front end to the iteration engine.
  typedef struct packed {
    logic signed [31:0] cre;
    logic signed [31:0] cim;
  } point_t;
endpackage

// File: rtl/mec_stream_if.sv
//------------------------------------------------------------------------------
// mec_stream_if
// Valid/ready channel carrying a generic payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mec_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mec_divider.sv
//------------------------------------------------------------------------------
// mec_divider
// Restoring signed division, one quotient bit per cycle, truncated to zero.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mec_divider import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,
  input  logic [GridW-1:0]   den_i,
  output logic               done_o,
  output logic signed [32:0] quot_o
);
  logic [32:0] rem_q, rem_d, quo_q, quo_d;
  logic [GridW-1:0] den_q;
  logic neg_q;
  logic [5:0] cnt_q;
  logic busy_q;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_q[31:0], quo_q[32]};
    trial   = {1'b0, shifted} - {21'd0, den_q};
    quo_d   = {quo_q[31:0], ~trial[33]};
    rem_d   = trial[33] ? shifted : trial[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd33;
        rem_q  <= '0;
        quo_q  <= num_i[32] ? 33'(-num_i) : num_i;
        neg_q  <= num_i[32];
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// File: rtl/mec_front.sv
//------------------------------------------------------------------------------
// mec_front
// Accepts pixels, works out the step sizes and the point c.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mec_front import mec_pkg::*; #(
  parameter int unsigned MaxDim = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [BoundW-1:0] re_min_i,
  input  logic signed [BoundW-1:0] re_max_i,
  input  logic signed [BoundW-1:0] im_min_i,
  input  logic signed [BoundW-1:0] im_max_i,
  input  logic [GridW-1:0]         width_i,
  input  logic [GridW-1:0]         height_i,
  mec_stream_if.sink               pix,
  mec_stream_if.source             pnt
);
  typedef enum logic [2:0] {SIdle, SDivX, SDivY, SMul, SOut} state_e;
  state_e state_q;
  logic [CoordW-1:0] col_q, row_q;
  logic signed [32:0] stepx_q, quot;
  logic signed [46:0] prx_q, pry_q;
  logic div_start, div_done;
  logic [GridW-1:0] den;
  logic signed [32:0] num;
  logic signed [47:0] sx, sy;
  logic signed [31:0] cre, cim;

  function automatic logic [GridW-1:0] dim(input logic [GridW-1:0] n);
    if (n == '0) return GridW'(1);
    if (32'(n) > MaxDim) return GridW'(MaxDim);
    return n;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [47:0] v);
    if (v > 48'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign div_start = (state_q == SIdle && pix.valid) || (state_q == SDivX && div_done);
  assign den = (state_q == SIdle) ? dim(width_i) : dim(height_i);
  assign num = (state_q == SIdle) ? 33'(re_max_i) - 33'(re_min_i)
                                  : 33'(im_max_i) - 33'(im_min_i);

  mec_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quot_o(quot)
  );

  assign pix.ready = (state_q == SIdle);
  assign sx = 48'(re_min_i) + 48'(prx_q);
  assign sy = 48'(im_max_i) - 48'(pry_q);
  assign cre = sat(sx);
  assign cim = sat(sy);
  assign pnt.valid = (state_q == SOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: if (pix.valid) begin
          col_q   <= pix.data[CoordW-1:0];
          row_q   <= pix.data[2*CoordW-1:CoordW];
          state_q <= SDivX;
        end
        SDivX: if (div_done) begin
          stepx_q <= quot;
          state_q <= SDivY;
        end
        SDivY: if (div_done) begin
          prx_q   <= 47'($signed({1'b0, col_q})) * 47'(stepx_q);
          pry_q   <= 47'($signed({1'b0, row_q})) * 47'(quot);
          state_q <= SMul;
        end
        SMul: begin
          pnt.data <= {cre, cim};
          state_q  <= SOut;
        end
        SOut: if (pnt.ready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: rtl/mec_queue.sv
//------------------------------------------------------------------------------
// mec_queue
// Two-entry point queue between front end and iteration engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mec_queue import mec_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mec_stream_if.sink    in,
  mec_stream_if.source  out
);
  point_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in.ready  = (cnt_q != 2'd2);
  assign out.valid = (cnt_q != 2'd0);
  assign out.data  = mem_q[rp_q];
  assign push = in.valid && in.ready;
  assign pop  = out.valid && out.ready;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/mec_engine.sv
//------------------------------------------------------------------------------
// mec_engine
// Iterates z = z*z + c, multiply state then update state; holds the result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mec_engine import mec_pkg::*; #(
  parameter int unsigned FracBits = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LimitW-1:0] limit_i,
  mec_stream_if.sink        pnt,
  mec_stream_if.source      res
);
  typedef enum logic [1:0] {SIdle, SMul, SUpd, SOut} state_e;
  state_e state_q;
  logic signed [31:0] cre_q, cim_q, zr_q, zi_q;
  logic signed [63:0] rr_q, ii_q, ri_q;
  logic [LimitW-1:0] cnt_q;
  logic [64:0] sq;
  logic signed [64:0] dre, dim2;
  logic signed [65:0] nre, nim;
  logic signed [31:0] zr_n, zi_n;
  logic [64:0] lim_sq;

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign lim_sq = 65'd16 << (2 * FracBits);
  assign sq   = 65'(rr_q) + 65'(ii_q);
  assign dre  = (65'(rr_q) - 65'(ii_q)) >>> FracBits;
  assign dim2 = (65'(ri_q) <<< 1) >>> FracBits;
  assign nre  = 66'(dre) + 66'(cre_q);
  assign nim  = 66'(dim2) + 66'(cim_q);
  assign zr_n = sat(nre);
  assign zi_n = sat(nim);

  assign pnt.ready = (state_q == SIdle);
  assign res.valid = (state_q == SOut);
  assign res.data  = cnt_q[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (pnt.valid) begin
          cre_q <= pnt.data[63:32];
          cim_q <= pnt.data[31:0];
          zr_q <= '0; zi_q <= '0;
          cnt_q <= '0;
          state_q <= SMul;
        end
        SMul: begin
          rr_q <= 64'(zr_q) * 64'(zr_q);
          ii_q <= 64'(zi_q) * 64'(zi_q);
          ri_q <= 64'(zr_q) * 64'(zi_q);
          state_q <= (cnt_q < limit_i) ? SUpd : SOut;
        end
        SUpd: begin
          if (sq >= lim_sq) begin
            state_q <= SOut;
          end else begin
            zr_q <= zr_n;
            zi_q <= zi_n;
            cnt_q <= cnt_q + 1'b1;
            state_q <= SMul;
          end
        end
        SOut: if (res.ready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: rtl/mandelbrot_escape_count_core.sv
//------------------------------------------------------------------------------
// mandelbrot_escape_count_core
// Escape count for one pixel of a configurable region of the plane.
//------------------------------------------------------------------------------
// The front end runs two serial divisions, a multiply and a saturate; the
//   point passes through the queue, then the engine iterates until escape or
//   until the limit ends the run, and the result is offered.
// The front end takes a new pixel while the engine still iterates, so the
//   slower of the front end and the iteration engine sets the pace.
// Reset: asynchronous, active low; only control and config registers reset.
`timescale 1ns / 1ps
module mandelbrot_escape_count_core import mec_pkg::*; #(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mec_stream_if.sink        pix_i,
  mec_stream_if.source      res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  // Configuration registers
  logic signed [BoundW-1:0] re_min_q, re_max_q, im_min_q, im_max_q;
  logic [GridW-1:0]  width_q, height_q;
  logic [LimitW-1:0] limit_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_min_q <= -31'sd134217728;
      re_max_q <= 31'sd67108864;
      im_min_q <= -31'sd83886080;
      im_max_q <= 31'sd83886080;
      width_q  <= 13'd600;
      height_q <= 13'd600;
      limit_q  <= 16'd255;
    end else if (wr) begin
      unique case (paddr)
        RegReMin:  re_min_q <= pwdata[BoundW-1:0];
        RegReMax:  re_max_q <= pwdata[BoundW-1:0];
        RegImMin:  im_min_q <= pwdata[BoundW-1:0];
        RegImMax:  im_max_q <= pwdata[BoundW-1:0];
        RegWidth:  width_q  <= pwdata[GridW-1:0];
        RegHeight: height_q <= pwdata[GridW-1:0];
        RegLimit:  limit_q  <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegReMin:  prdata = 32'(re_min_q);
      RegReMax:  prdata = 32'(re_max_q);
      RegImMin:  prdata = 32'(im_min_q);
      RegImMax:  prdata = 32'(im_max_q);
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      RegLimit:  prdata = 32'(limit_q);
      default:   prdata = '0;
    endcase
  end

  mec_stream_if #(.W(64)) front_pnt ();
  mec_stream_if #(.W(64)) back_pnt ();

  // Front end: steps by serial division, then the point c
  mec_front #(.MaxDim(MAX_DIM)) u_front (
    .clk_i, .rst_ni,
    .re_min_i(re_min_q), .re_max_i(re_max_q),
    .im_min_i(im_min_q), .im_max_i(im_max_q),
    .width_i(width_q), .height_i(height_q),
    .pix(pix_i), .pnt(front_pnt)
  );

  // Short queue decouples the two halves
  mec_queue u_queue (.clk_i, .rst_ni, .in(front_pnt), .out(back_pnt));

  // Back end: the iteration loop, result held until taken
  mec_engine #(.FracBits(FRAC_BITS)) u_engine (
    .clk_i, .rst_ni, .limit_i(limit_q), .pnt(back_pnt), .res(res_o)
  );
endmodule

// File: rtl/mec_checker.sv
//------------------------------------------------------------------------------
// mec_checker
// Port-level checks on the escape count core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_count_core_defines.svh"
module mec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data,
  input logic        pready
);
  `MEC_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `MEC_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, out_valid && !out_ready, $stable(out_data))
  `MEC_ASSERT_IMPL(a_pready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind mandelbrot_escape_count_core mec_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(res_o.valid), .out_ready(res_o.ready),
  .out_data(res_o.data), .pready(pready)
);

// File: tb/sv/tb_mandelbrot_escape_count_core.sv
//------------------------------------------------------------------------------
// tb_mandelbrot_escape_count_core
// Self-checking bench: pixels stream in, escape counts are checked against a
// fixed-point predictor; region, grid and limit are changed between phases.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_mandelbrot_escape_count_core;
  import mec_pkg::*;

  localparam int unsigned DimMax   = 4096;
  localparam int unsigned FracBits = 26;
  localparam int unsigned Watchdog = 400000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  mec_stream_if #(.W(2*CoordW)) pix_if ();
  mec_stream_if #(.W(CountW))   res_if ();

  mandelbrot_escape_count_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor's copy of the registers
  logic signed [30:0] re_lo, re_hi, im_lo, im_hi;
  logic [12:0] cols, rows;
  logic [15:0] iter_cap;

  logic [2*CoordW-1:0] pixel_q[$];   // items waiting for the driver
  logic [CountW-1:0]   count_q[$];   // predicted escape counts
  int  mismatches;
  int  idle_cycles;
  bit  quiet;       // no idling in the last part
  bit  hold_long;   // receiver held off for a long stretch
  int  send_gap, recv_gap;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint eff_dim(logic [12:0] n);
    if (n == 0) return 1;
    if (n > DimMax) return DimMax;
    return n;
  endfunction

  function automatic logic [CountW-1:0] escape_count(logic [11:0] col, logic [11:0] row);
    longint sx, sy, cr, ci, zr, zi, nr, ni;
    longint unsigned ar, ai, sq, bound;
    int unsigned n;
    sx = (longint'(re_hi) - longint'(re_lo)) / eff_dim(cols);
    sy = (longint'(im_hi) - longint'(im_lo)) / eff_dim(rows);
    cr = sat_word(longint'(re_lo) + longint'(col) * sx);
    ci = sat_word(longint'(im_hi) - longint'(row) * sy);
    zr = 0;
    zi = 0;
    n = 0;
    bound = 64'd16 << (2*FracBits);
    while (n < iter_cap) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      sq = ar*ar + ai*ai;
      if (sq >= bound) break;
      // >>> on signed longint floors, as wanted
      nr = sat_word(((zr*zr - zi*zi) >>> FracBits) + cr);
      ni = sat_word(((2*zr*zi) >>> FracBits) + ci);
      zr = nr;
      zi = ni;
      n++;
    end
    return n[CountW-1:0];
  endfunction

  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      RegReMin:  re_lo    = val[30:0];
      RegReMax:  re_hi    = val[30:0];
      RegImMin:  im_lo    = val[30:0];
      RegImMax:  im_hi    = val[30:0];
      RegWidth:  cols     = val[12:0];
      RegHeight: rows     = val[12:0];
      RegLimit:  iter_cap = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_region(int rl, int rh, int il, int ih, int w, int h, int lim);
    reg_write(RegReMin, rl);
    reg_write(RegReMax, rh);
    reg_write(RegImMin, il);
    reg_write(RegImMax, ih);
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    reg_write(RegLimit, lim);
  endtask

  task automatic queue_pixel(logic [11:0] col, logic [11:0] row);
    pixel_q.push_back({row, col});
    count_q.push_back(escape_count(col, row));
  endtask

  // Wait for the block to drain; every item gives a result
  task automatic drain();
    while (pixel_q.size() != 0 || count_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly pixels inside the grid, some anywhere in the coordinate range
  task automatic random_phase(int n);
    int wc, hc;
    wc = eff_dim(cols);
    hc = eff_dim(rows);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        queue_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      else
        queue_pixel(12'($urandom_range(0, (wc > 4096 ? 4096 : wc) - 1)),
                    12'($urandom_range(0, (hc > 4096 ? 4096 : hc) - 1)));
    end
    drain();
  endtask

  // Sender: one item per handshake, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.data  <= '0;
      send_gap     <= 0;
    end else begin
      // an accepted item leaves the queue, so its head is always the next item
      if (pix_if.valid && pix_if.ready) void'(pixel_q.pop_front());
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        pix_if.valid <= 1'b0;
      end else if (!quiet && !(pix_if.valid && !pix_if.ready) && $urandom_range(0, 7) == 0) begin
        send_gap     <= $urandom_range(0, 8);
        pix_if.valid <= 1'b0;
      end else begin
        pix_if.valid <= pixel_q.size() > 0;
        if (pixel_q.size() > 0) pix_if.data <= pixel_q[0];
      end
    end
  end

  // Receiver: stalls in bursts, and once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap     <= 0;
    end else if (hold_long) begin
      recv_gap     <= 3000;
      res_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap     <= recv_gap - 1;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap     <= $urandom_range(0, 8);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (res_if.valid && res_if.ready) begin
        if (count_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected escape count %0d", res_if.data);
        end else begin
          if (res_if.data !== count_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("escape_count mismatch: expected %0d, got %0d", count_q[0], res_if.data);
          end
          void'(count_q.pop_front());
        end
      end
      if (idle_cycles >= Watchdog) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_long   = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    re_lo = -31'sd134217728; re_hi = 31'sd67108864;
    im_lo = -31'sd83886080;  im_hi = 31'sd83886080;
    cols = 13'd600; rows = 13'd600; iter_cap = 16'd255;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset region, corners, pixels beyond the grid
    queue_pixel(0, 0);
    queue_pixel(300, 300);
    queue_pixel(599, 599);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(12'haaa, 12'h555);
    queue_pixel(400, 300);        // inside the set, count hits the limit
    drain();

    // Zero limit, zero grid sizes, extreme bounds
    set_region(-536870912, 536870912, -536870912, 536870912, 0, 0, 0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();
    // Oversized grid, counts wrapping past 256, inverted bounds
    set_region(536870912, -536870912, 536870912, -536870912, 8191, 8191, 300);
    queue_pixel(2048, 2048);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    drain();
    // Tiny region at the origin: long runs, count modulo 256
    set_region(-1000, 1000, -1000, 1000, 1, 1, 700);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(4095, 4095);      // extrapolates past the region, c stays in range
    drain();
    set_region(-536870912, -536870912, 536870912, 536870912, 4096, 4097, 1);
    queue_pixel(123, 4000);
    queue_pixel(4095, 4095);
    drain();

    // Random phases over several settings
    set_region(-134217728, 67108864, -83886080, 83886080, 64, 48, 60);
    // receiver holds off while the sender keeps offering
    hold_long = 1'b1;
    repeat (2) @(posedge clk_i);
    hold_long = 1'b0;
    random_phase(250);
    repeat (4) begin
      set_region(($signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824) >>> 1,
                 ($signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824) >>> 1,
                 ($signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824) >>> 1,
                 ($signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824) >>> 1,
                 $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 120));
      random_phase(150);
    end
    set_region(-150994944, 50331648, -75497472, 75497472, 200, 150, 255);
    random_phase(250);
    set_region(-1073741824, 1073741823, -1073741824, 1073741823, 4095, 1, 65535);
    random_phase(10);
    set_region(-134217728, 67108864, -83886080, 83886080, 32, 32, 40);
    quiet = 1'b1;
    random_phase(150);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/mec_pkg.sv
rtl/mec_stream_if.sv
rtl/mec_divider.sv
rtl/mec_front.sv
rtl/mec_queue.sv
rtl/mec_engine.sv
rtl/mandelbrot_escape_count_core.sv
rtl/mec_checker.sv
tb/sv/tb_mandelbrot_escape_count_core.sv
